@@ design/gic_pkg.sv @@
`timescale 1ns / 1ps
// gamepad input conditioner: shared types, widths and reset values
// no dependencies; used by gamepad_input_conditioner_unit
package gic_pkg;

    localparam int NUM_BUTTONS_DEF = 11;

    localparam int STICK_W = 8;
    localparam int TIME_W  = 20;
    localparam int MOVE_W  = 10;
    localparam int DIR_W   = 2;
    localparam int THR_W   = 9;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 8;

    // shared subtractor width, covers the radicand of the square root
    localparam int ALU_W   = 34;
    localparam int ROOT_W  = 17;
    localparam int REM_W   = 25;
    localparam int QUO_W   = 9;
    localparam int LEN2_W  = 18;
    localparam int MAG_W   = 9;

    localparam logic [4:0] SQRT_LAST_ITER = 5'd16;
    localparam logic [4:0] DIV_LAST_ITER  = 5'd8;

    localparam logic [LEN2_W-1:0] UNIT_LEN2 = 18'd16384;

    localparam int BIT_UP    = 5;
    localparam int BIT_DOWN  = 6;
    localparam int BIT_LEFT  = 7;
    localparam int BIT_RIGHT = 8;

    localparam logic [IDX_W-1:0] CFG_DEADZONE  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_THRESHOLD = 8'd1;
    localparam logic [IDX_W-1:0] CFG_DELAY     = 8'd2;
    localparam logic [IDX_W-1:0] CFG_INTERVAL  = 8'd3;

    localparam logic [STICK_W-1:0] DEADZONE_RST  = 8'd28;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 9'd140;
    localparam logic [TIME_W-1:0]  DELAY_RST     = 20'd340000;
    localparam logic [TIME_W-1:0]  INTERVAL_RST  = 20'd110000;

    localparam logic signed [DIR_W-1:0] DIR_NONE  = 2'sd0;
    localparam logic signed [DIR_W-1:0] DIR_PLUS  = 2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_MINUS = -2'sd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHECK,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_TIMV,
        ST_TIMH,
        ST_DONE
    } state_t;

    function automatic logic [MAG_W-1:0] abs_move(input logic signed [MOVE_W-1:0] v);
        logic signed [MOVE_W-1:0] n;
        n = -v;
        return v[MOVE_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    function automatic logic signed [DIR_W-1:0] menu_dir(
        input logic                      plus_btn,
        input logic                      minus_btn,
        input logic signed [MOVE_W-1:0]  comp,
        input logic [THR_W-1:0]          thr
    );
        logic signed [MOVE_W+1:0] c;
        logic signed [MOVE_W+1:0] th;
        c  = (MOVE_W+2)'(comp);
        th = $signed({3'b000, thr});
        if (plus_btn || c > th)
            return DIR_PLUS;
        else if (minus_btn || c < -th)
            return DIR_MINUS;
        else
            return DIR_NONE;
    endfunction

endpackage

@@ design/gamepad_input_conditioner_unit.sv @@
`timescale 1ns / 1ps
// gamepad input conditioner top level: button edges, deadzone stick vector
// with unit clamp by shared subtractor (sqrt, divide, repeat timers); uses gic_pkg
//
// channel   dir  fields (low bit first)
// s_axis    in   buttons, stick_x, stick_y, elapsed_us
// m_axis    out  held, pressed, released, move_x, move_y, menu_vertical,
//                menu_horizontal
// cfg       in   write enable, register index, data
//
// a normalized beat runs 17 square root steps and 2 x 9 divide steps, all
// through the one shared 34-bit compare-subtract unit, plus one step per
// repeat timer; a vector within unit length skips the root and the divides.
// s_axis_tready is high only between beats; a finished result sits in the
// output register so the next beat can be taken while m_axis waits.
// reset (rst_n, async low) clears state, timers and the output valid.
module gamepad_input_conditioner_unit #(
    parameter int NUM_BUTTONS = gic_pkg::NUM_BUTTONS_DEF,
    localparam int IN_W  = ((NUM_BUTTONS + 2*gic_pkg::STICK_W + gic_pkg::TIME_W + 7) / 8) * 8,
    localparam int OUT_W = ((3*NUM_BUTTONS + 2*gic_pkg::MOVE_W + 2*gic_pkg::DIR_W + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // buttons, stick_x, stick_y, elapsed_us
    input  logic [IN_W-1:0]              s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // held, pressed, released, move_x, move_y, menu_vertical, menu_horizontal
    output logic [OUT_W-1:0]             m_axis_tdata,
    input  logic                         cfg_we,
    input  logic [gic_pkg::IDX_W-1:0]    cfg_index,
    input  logic [gic_pkg::CFG_W-1:0]    cfg_data
);

    localparam int NB   = NUM_BUTTONS;
    localparam int SW   = gic_pkg::STICK_W;
    localparam int TW   = gic_pkg::TIME_W;
    localparam int MW   = gic_pkg::MOVE_W;
    localparam int DW   = gic_pkg::DIR_W;
    localparam int AW   = gic_pkg::ALU_W;
    localparam int RW   = gic_pkg::ROOT_W;
    localparam int REMW = gic_pkg::REM_W;
    localparam int QW   = gic_pkg::QUO_W;
    localparam int L2W  = gic_pkg::LEN2_W;
    localparam int MGW  = gic_pkg::MAG_W;

    // configuration
    logic [SW-1:0]            deadzone_reg;
    logic [gic_pkg::THR_W-1:0] threshold_reg;
    logic [TW-1:0]            delay_reg;
    logic [TW-1:0]            interval_reg;

    gic_pkg::state_t state_reg, state_next;

    logic [4:0]               iter_reg, iter_next;
    logic [NB-1:0]            btn_reg, btn_next;
    logic [NB-1:0]            prev_reg, prev_next;
    logic [TW-1:0]            dt_reg, dt_next;
    logic [3:0]               dpad_reg, dpad_next;   // up, down, left, right
    logic signed [MW-1:0]     mx_reg, mx_next;
    logic signed [MW-1:0]     my_reg, my_next;
    logic [L2W-1:0]           len2_reg, len2_next;
    logic [AW-1:0]            rad_reg, rad_next;
    logic [AW-1:0]            root_reg, root_next;
    logic [REMW-1:0]          rem_reg, rem_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic signed [MW-1:0]     vx_reg, vx_next;
    logic signed [MW-1:0]     vy_reg, vy_next;
    logic signed [DW-1:0]     vdir_reg, vdir_next;
    logic signed [DW-1:0]     hdir_reg, hdir_next;
    logic [TW-1:0]            vtim_reg, vtim_next;
    logic [TW-1:0]            htim_reg, htim_next;
    logic signed [DW-1:0]     mv_reg, mv_next;
    logic signed [DW-1:0]     mh_reg, mh_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         out_data_reg, out_data_next;

    // shared compare-subtract unit
    logic [AW-1:0]            alu_a;
    logic [AW-1:0]            alu_b;
    logic [AW:0]              alu_diff;
    logic                     alu_borrow;

    logic                     in_beat;
    logic                     out_load;
    logic                     norm_needed;

    // input field split
    logic [NB-1:0]            in_buttons;
    logic [SW-1:0]            in_stick_x;
    logic [SW-1:0]            in_stick_y;
    logic [TW-1:0]            in_elapsed;
    logic [31:0]              btn_wide;

    logic signed [SW:0]       ax_raw, ay_raw;
    logic [SW:0]              ax_mag, ay_mag;
    logic signed [MW-1:0]     ax, ay;

    logic [MGW-1:0]           magx, magy;
    logic [L2W-1:0]           sqx, sqy;
    logic [AW-1:0]            one_bit;
    logic [QW-1:0]            quo_full;
    logic signed [MW-1:0]     quo_signed;
    logic signed [DW-1:0]     dir_v, dir_h;
    logic                     tim_fire;

    assign in_buttons = s_axis_tdata[NB-1:0];
    assign in_stick_x = s_axis_tdata[NB+SW-1:NB];
    assign in_stick_y = s_axis_tdata[NB+2*SW-1:NB+SW];
    assign in_elapsed = s_axis_tdata[NB+2*SW+TW-1:NB+2*SW];
    assign btn_wide   = 32'(in_buttons);

    assign s_axis_tready = (state_reg == gic_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_load      = (state_reg == gic_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    // centred stick with deadzone
    always_comb
    begin
        ax_raw = $signed({1'b0, in_stick_x}) - $signed(9'd128);
        ay_raw = $signed({1'b0, in_stick_y}) - $signed(9'd128);
        ax_mag = ax_raw[SW] ? 9'(-ax_raw) : 9'(ax_raw);
        ay_mag = ay_raw[SW] ? 9'(-ay_raw) : 9'(ay_raw);
        ax = (ax_mag <= {1'b0, deadzone_reg}) ? '0 : MW'(ax_raw);
        ay = (ay_mag <= {1'b0, deadzone_reg}) ? '0 : MW'(ay_raw);
    end

    assign magx = gic_pkg::abs_move(mx_reg);
    assign magy = gic_pkg::abs_move(my_reg);
    assign sqx  = L2W'(magx) * L2W'(magx);
    assign sqy  = L2W'(magy) * L2W'(magy);
    assign norm_needed = len2_reg > gic_pkg::UNIT_LEN2;
    assign one_bit = AW'(1) << {iter_reg, 1'b0};

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[AW];

    assign quo_full = {quo_reg[QW-2:0], !alu_borrow};
    assign dir_v = gic_pkg::menu_dir(dpad_reg[1], dpad_reg[0], vy_reg, threshold_reg);
    assign dir_h = gic_pkg::menu_dir(dpad_reg[3], dpad_reg[2], vx_reg, threshold_reg);
    assign tim_fire = alu_borrow || (alu_diff[TW-1:0] == '0);

    always_comb
    begin
        quo_signed = MW'(quo_full);
        if ((state_reg == gic_pkg::ST_DIVX && mx_reg[MW-1]) ||
            (state_reg == gic_pkg::ST_DIVY && my_reg[MW-1]))
            quo_signed = -MW'(quo_full);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gic_pkg::ST_IDLE:  if (in_beat) state_next = gic_pkg::ST_LEN;
            gic_pkg::ST_LEN:   state_next = gic_pkg::ST_CHECK;
            gic_pkg::ST_CHECK: state_next = norm_needed ? gic_pkg::ST_SQRT : gic_pkg::ST_TIMV;
            gic_pkg::ST_SQRT:  if (iter_reg == '0) state_next = gic_pkg::ST_DIVX;
            gic_pkg::ST_DIVX:  if (iter_reg == '0) state_next = gic_pkg::ST_DIVY;
            gic_pkg::ST_DIVY:  if (iter_reg == '0) state_next = gic_pkg::ST_TIMV;
            gic_pkg::ST_TIMV:  state_next = gic_pkg::ST_TIMH;
            gic_pkg::ST_TIMH:  state_next = gic_pkg::ST_DONE;
            gic_pkg::ST_DONE:  if (out_load) state_next = gic_pkg::ST_IDLE;
            default:           state_next = gic_pkg::ST_IDLE;
        endcase
    end

    // shared unit operand select
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        unique case (state_reg)
            gic_pkg::ST_SQRT:
            begin
                alu_a = rad_reg;
                alu_b = root_reg | one_bit;
            end
            gic_pkg::ST_DIVX, gic_pkg::ST_DIVY:
            begin
                alu_a = AW'(rem_reg);
                alu_b = AW'(root_reg[RW-1:0]) << iter_reg[3:0];
            end
            gic_pkg::ST_TIMV:
            begin
                alu_a = AW'(vtim_reg);
                alu_b = AW'(dt_reg);
            end
            gic_pkg::ST_TIMH:
            begin
                alu_a = AW'(htim_reg);
                alu_b = AW'(dt_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        iter_next      = iter_reg;
        btn_next       = btn_reg;
        prev_next      = prev_reg;
        dt_next        = dt_reg;
        dpad_next      = dpad_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        len2_next      = len2_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vdir_next      = vdir_reg;
        hdir_next      = hdir_reg;
        vtim_next      = vtim_reg;
        htim_next      = htim_reg;
        mv_next        = mv_reg;
        mh_next        = mh_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            gic_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    btn_next  = in_buttons;
                    dt_next   = in_elapsed;
                    dpad_next = {btn_wide[gic_pkg::BIT_RIGHT], btn_wide[gic_pkg::BIT_LEFT],
                                 btn_wide[gic_pkg::BIT_DOWN], btn_wide[gic_pkg::BIT_UP]};
                    mx_next = ax + (btn_wide[gic_pkg::BIT_RIGHT] ? MW'(128) : MW'(0))
                                 - (btn_wide[gic_pkg::BIT_LEFT]  ? MW'(128) : MW'(0));
                    my_next = ay + (btn_wide[gic_pkg::BIT_DOWN] ? MW'(128) : MW'(0))
                                 - (btn_wide[gic_pkg::BIT_UP]   ? MW'(128) : MW'(0));
                end
            end
            gic_pkg::ST_LEN:
            begin
                len2_next = sqx + sqy;
            end
            gic_pkg::ST_CHECK:
            begin
                rad_next  = AW'(len2_reg) << 16;
                root_next = '0;
                iter_next = gic_pkg::SQRT_LAST_ITER;
                vx_next   = mx_reg <<< 1;
                vy_next   = my_reg <<< 1;
            end
            gic_pkg::ST_SQRT:
            begin
                if (!alu_borrow)
                begin
                    rad_next  = alu_diff[AW-1:0];
                    root_next = (root_reg >> 1) | one_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                iter_next = iter_reg - 5'd1;
                if (iter_reg == '0)
                begin
                    iter_next = gic_pkg::DIV_LAST_ITER;
                    rem_next  = REMW'(magx) << 16;
                    quo_next  = '0;
                end
            end
            gic_pkg::ST_DIVX, gic_pkg::ST_DIVY:
            begin
                if (!alu_borrow)
                    rem_next = alu_diff[REMW-1:0];
                quo_next  = quo_full;
                iter_next = iter_reg - 5'd1;
                if (iter_reg == '0)
                begin
                    if (state_reg == gic_pkg::ST_DIVX)
                    begin
                        vx_next   = quo_signed;
                        iter_next = gic_pkg::DIV_LAST_ITER;
                        rem_next  = REMW'(magy) << 16;
                        quo_next  = '0;
                    end
                    else
                    begin
                        vy_next = quo_signed;
                    end
                end
            end
            gic_pkg::ST_TIMV:
            begin
                if (dir_v == gic_pkg::DIR_NONE)
                begin
                    vdir_next = gic_pkg::DIR_NONE;
                    vtim_next = '0;
                    mv_next   = gic_pkg::DIR_NONE;
                end
                else if (dir_v != vdir_reg)
                begin
                    vdir_next = dir_v;
                    vtim_next = delay_reg;
                    mv_next   = dir_v;
                end
                else if (tim_fire)
                begin
                    vtim_next = interval_reg;
                    mv_next   = dir_v;
                end
                else
                begin
                    vtim_next = alu_diff[TW-1:0];
                    mv_next   = gic_pkg::DIR_NONE;
                end
            end
            gic_pkg::ST_TIMH:
            begin
                if (dir_h == gic_pkg::DIR_NONE)
                begin
                    hdir_next = gic_pkg::DIR_NONE;
                    htim_next = '0;
                    mh_next   = gic_pkg::DIR_NONE;
                end
                else if (dir_h != hdir_reg)
                begin
                    hdir_next = dir_h;
                    htim_next = delay_reg;
                    mh_next   = dir_h;
                end
                else if (tim_fire)
                begin
                    htim_next = interval_reg;
                    mh_next   = dir_h;
                end
                else
                begin
                    htim_next = alu_diff[TW-1:0];
                    mh_next   = gic_pkg::DIR_NONE;
                end
            end
            gic_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({mh_reg, mv_reg, vy_reg, vx_reg,
                                             ~btn_reg & prev_reg,
                                             btn_reg & ~prev_reg,
                                             btn_reg});
                    prev_next = btn_reg;
                end
            end
            default:
            begin
                iter_next = iter_reg;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= gic_pkg::DEADZONE_RST;
            threshold_reg <= gic_pkg::THRESHOLD_RST;
            delay_reg     <= gic_pkg::DELAY_RST;
            interval_reg  <= gic_pkg::INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gic_pkg::CFG_DEADZONE)
                deadzone_reg <= cfg_data[SW-1:0];
            if (cfg_index == gic_pkg::CFG_THRESHOLD)
                threshold_reg <= cfg_data[gic_pkg::THR_W-1:0];
            if (cfg_index == gic_pkg::CFG_DELAY)
                delay_reg <= cfg_data[TW-1:0];
            if (cfg_index == gic_pkg::CFG_INTERVAL)
                interval_reg <= cfg_data[TW-1:0];
        end
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gic_pkg::ST_IDLE;
            iter_reg      <= '0;
            prev_reg      <= '0;
            vdir_reg      <= gic_pkg::DIR_NONE;
            hdir_reg      <= gic_pkg::DIR_NONE;
            vtim_reg      <= '0;
            htim_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            prev_reg      <= prev_next;
            vdir_reg      <= vdir_next;
            hdir_reg      <= hdir_next;
            vtim_reg      <= vtim_next;
            htim_reg      <= htim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        btn_reg      <= btn_next;
        dt_reg       <= dt_next;
        dpad_reg     <= dpad_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        len2_reg     <= len2_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        mv_reg       <= mv_next;
        mh_reg       <= mh_next;
        out_data_reg <= out_data_next;
    end

endmodule
